@@ hw/rtl/harwm_pkg.sv @@
// Shared constants, register codes and reset values for the HAR window-means block.
`timescale 1ns / 1ps

package harwm_pkg;

    localparam int SAMPLE_W      = 32;   // Q16.16 sample and mean width
    localparam int LAG_OUTS      = 4;    // lag mean fields in a result row
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 6;
    localparam int LAG_CNT_W     = 3;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int MAX_HORIZON_DEF = 32;
    localparam int LAG_SLOTS_DEF   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAG_COUNT = 3'd0,
        CFG_PERIOD_0  = 3'd1,
        CFG_PERIOD_1  = 3'd2,
        CFG_PERIOD_2  = 3'd3,
        CFG_PERIOD_3  = 3'd4,
        CFG_HORIZON   = 3'd5
    } t_cfg_idx;

    localparam logic [LAG_CNT_W-1:0]  RST_LAG_COUNT = 3'd3;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD_0  = 6'd1;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD_1  = 6'd5;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD_2  = 6'd22;
    localparam logic [CFG_DATA_W-1:0] RST_PERIOD_3  = 6'd1;
    localparam logic [CFG_DATA_W-1:0] RST_HORIZON   = 6'd1;

endpackage

@@ hw/rtl/har_window_means_top.sv @@
// Top level: sample ring, accumulate and divide sequencer, config and output registers.
`timescale 1ns / 1ps
// Per accepted item: fill check, then for the target window (h) and each used lag (p_i) the
//   window is summed over the ring and divided; SUM_W = 37 at default sizes.
// Uses one ring read port and one shared 1-bit/cycle divider; input not ready meanwhile.
// A new sample is taken only once the current item is done, including any wait for a full
//   output register; an item that yields no row only passes the fill check.
// Reset (synchronous, active low): pointers, fill and config to defaults; ring not cleared.
module har_window_means_top #(
    parameter int MAX_WINDOW  = harwm_pkg::MAX_WINDOW_DEF,
    parameter int MAX_HORIZON = harwm_pkg::MAX_HORIZON_DEF,
    parameter int LAG_SLOTS   = harwm_pkg::LAG_SLOTS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // input stream
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  logic [harwm_pkg::SAMPLE_W-1:0]            i_s_axis_tdata,  // [31:0] sample
    input  logic                                      i_s_axis_tuser,  // [0] series_start
    // result stream
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // [31:0] target_mean, [63:32] lag_mean_0, [95:64] lag_mean_1,
    // [127:96] lag_mean_2, [159:128] lag_mean_3
    output logic [(harwm_pkg::LAG_OUTS+1)*harwm_pkg::SAMPLE_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [harwm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [harwm_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import harwm_pkg::*;

    localparam int DEPTH    = MAX_WINDOW + MAX_HORIZON;
    localparam int AW       = $clog2(DEPTH);
    localparam int FW       = $clog2(DEPTH + 1);
    localparam int MAXV     = (MAX_WINDOW > MAX_HORIZON) ? MAX_WINDOW : MAX_HORIZON;
    localparam int CW       = $clog2(MAXV + 1);
    localparam int SUM_W    = SAMPLE_W + $clog2(MAXV);
    localparam int SLOT_LIM = (LAG_SLOTS < LAG_OUTS) ? LAG_SLOTS : LAG_OUTS;
    localparam int JW       = $clog2(LAG_OUTS + 1);
    localparam int LIW      = $clog2(LAG_OUTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    function automatic logic [CW-1:0] f_clamp(input logic [CFG_DATA_W-1:0] v, input int hi);
        logic [CW-1:0] res;
        if (v == '0)
            res = CW'(1);
        else if (int'(v) > hi)
            res = CW'(hi);
        else
            res = CW'(v);
        return res;
    endfunction

    // config registers
    logic [LAG_CNT_W-1:0]  r_lag_count;
    logic [CFG_DATA_W-1:0] r_period [LAG_OUTS];
    logic [CFG_DATA_W-1:0] r_horizon;

    // control
    t_state                r_state;
    logic [AW-1:0]         r_wp;
    logic [FW-1:0]         r_fill;
    logic [JW-1:0]         r_job;
    logic [CW-1:0]         r_cnt;
    logic                  r_pend;
    logic                  r_div_start;
    logic                  r_out_vld;

    // payload
    logic [SAMPLE_W-1:0]   r_ring [DEPTH];
    logic [SAMPLE_W-1:0]   r_rd;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_lag_base;
    logic [SUM_W-1:0]      r_acc;
    logic [SAMPLE_W-1:0]   r_res [LAG_OUTS+1];
    logic [(LAG_OUTS+1)*SAMPLE_W-1:0] r_out_data;

    logic [CW-1:0]         h_c;
    logic [CW-1:0]         per_c [LAG_OUTS];
    logic [JW-1:0]         used_c;
    logic [CW-1:0]         maxp_c;
    logic [FW-1:0]         need_c;
    logic [CW-1:0]         job_cnt;
    logic                  in_acc;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         addr_dec;
    logic                  issue;
    logic                  div_done;
    logic [SAMPLE_W-1:0]   div_quo;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_idx          = i_s_axis_tuser ? '0 : r_wp;
    assign addr_dec        = (r_addr == '0) ? AW'(DEPTH - 1) : r_addr - AW'(1);

    always_comb begin
        h_c = f_clamp(r_horizon, MAX_HORIZON);
        for (int i = 0; i < LAG_OUTS; i++)
            per_c[i] = f_clamp(r_period[i], MAX_WINDOW);
        if (r_lag_count == '0)
            used_c = JW'(1);
        else if (int'(r_lag_count) > SLOT_LIM)
            used_c = JW'(SLOT_LIM);
        else
            used_c = JW'(r_lag_count);
        maxp_c = CW'(1);
        for (int i = 0; i < LAG_OUTS; i++)
            if ((JW'(i) < used_c) && (per_c[i] > maxp_c))
                maxp_c = per_c[i];
        need_c  = FW'(maxp_c) + FW'(h_c);
        job_cnt = (r_job == '0) ? h_c : per_c[LIW'(r_job - JW'(1))];
    end

    assign issue = (r_state == S_SUM) && (r_cnt != job_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_count <= RST_LAG_COUNT;
            r_period[0] <= RST_PERIOD_0;
            r_period[1] <= RST_PERIOD_1;
            r_period[2] <= RST_PERIOD_2;
            r_period[3] <= RST_PERIOD_3;
            r_horizon   <= RST_HORIZON;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LAG_COUNT: r_lag_count <= i_cfg_data[LAG_CNT_W-1:0];
                CFG_PERIOD_0:  r_period[0] <= i_cfg_data;
                CFG_PERIOD_1:  r_period[1] <= i_cfg_data;
                CFG_PERIOD_2:  r_period[2] <= i_cfg_data;
                CFG_PERIOD_3:  r_period[3] <= i_cfg_data;
                CFG_HORIZON:   r_horizon   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample ring: one write on accept, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_ring[wr_idx] <= i_s_axis_tdata;
        r_rd <= r_ring[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_job       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_SUM) && !issue && !r_pend;
            if ((r_state == S_OUT) && (!r_out_vld || i_m_axis_tready))
                r_out_vld <= 1'b1;
            else if (i_m_axis_tready)
                r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wp   <= (wr_idx == AW'(DEPTH - 1)) ? '0 : wr_idx + AW'(1);
                        if (i_s_axis_tuser)
                            r_fill <= FW'(1);
                        else if (r_fill != FW'(DEPTH))
                            r_fill <= r_fill + FW'(1);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_job  <= '0;
                    r_cnt  <= '0;
                    r_pend <= 1'b0;
                    r_state <= (r_fill < need_c) ? S_IDLE : S_SUM;
                end
                S_SUM: begin
                    if (issue)
                        r_cnt <= r_cnt + CW'(1);
                    r_pend <= issue;
                    if (!issue && !r_pend)
                        r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_job == used_c) begin
                            r_state <= S_OUT;
                        end else begin
                            r_job   <= r_job + JW'(1);
                            r_cnt   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || i_m_axis_tready)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc)
                    r_addr <= wr_idx;   // newest sample opens the target window
            end
            S_CHK: begin
                r_acc <= '0;
                for (int i = 0; i <= LAG_OUTS; i++)
                    r_res[i] <= '0;
            end
            S_SUM: begin
                if (issue)
                    r_addr <= addr_dec;
                if (r_pend)
                    r_acc <= r_acc + SUM_W'(r_rd);
                // after the target window the read pointer sits on the first lag sample
                if (!issue && !r_pend && (r_job == '0))
                    r_lag_base <= r_addr;
            end
            S_DIV: begin
                if (div_done) begin
                    r_res[r_job] <= div_quo;
                    r_acc        <= '0;
                    r_addr       <= r_lag_base;
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_m_axis_tready)
                    for (int i = 0; i <= LAG_OUTS; i++)
                        r_out_data[i*SAMPLE_W +: SAMPLE_W] <= r_res[i];
            end
            default: ;
        endcase
    end

    harwm_div #(
        .SUM_W (SUM_W),
        .DIV_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (job_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV))
        else $error("divider started outside divide phase");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SUM) || (r_state == S_DIV)) |-> (r_job <= used_c))
        else $error("job index beyond lags in use");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (r_cnt <= job_cnt))
        else $error("read count overran window");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_vld && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("row left sequencer while output register full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond ring depth");

endmodule

@@ hw/rtl/harwm_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all means of a row.
`timescale 1ns / 1ps

module harwm_div #(
    parameter int SUM_W = 37,
    parameter int DIV_W = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [SUM_W-1:0]                i_dividend,
    input  logic [DIV_W-1:0]                i_divisor,
    output logic                            o_done,
    output logic [harwm_pkg::SAMPLE_W-1:0]  o_quotient
);
    import harwm_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_div;

    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;
    logic               fits;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of r_quo while quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[SAMPLE_W-1:0];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held longer than one cycle");

endmodule
